### rtl/sdx_pkg.sv
`timescale 1ns / 1ps
package sdx_pkg;

  localparam int unsigned SDX_FIFO_DEPTH = 2;
  localparam int unsigned SDX_DIGITS     = 3;

  // one classified byte on its way from the front to the back
  typedef struct packed {
    logic       first;  // first byte of a word
    logic       zero;   // byte was zero
    logic [7:0] lead;   // leading letter (first byte only)
    logic [2:0] code;   // digit 1..6, 0 when skipped; lead as digit on a first byte
    logic       last;   // last byte of the word
  } sdx_item_t;

endpackage

### rtl/soundex_encoder.sv
`timescale 1ns / 1ps
// channel  | dir | signals                     | content
// s_axis   | in  | tvalid tready tdata tlast   | one byte of a word, tlast on its last byte
// m_axis   | out | tvalid tready tdata         | one Soundex code per word
//
// One byte enters per cycle while the queue has room; the front classifies it in the
// same cycle and writes a small queue, the back applies it to the code state once
// it pops it. A code is registered and valid on m_axis once its last byte is popped.
// Reset clears the queue, word tracking and the result valid flag.
// A stalled result stops the back only at a last byte; bytes behind it fill the queue.
module soundex_encoder #(
  parameter int unsigned FifoDepth = sdx_pkg::SDX_FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] character
  input  logic        s_axis_tlast,   // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [7:0] first_letter, [10:8] digit_one,
                                      // [13:11] digit_two, [16:14] digit_three
);

  sdx_pkg::sdx_item_t item_in, item_out;
  logic push, pop, full, empty;
  logic [7:0] first_letter;
  logic [2:0] digit_one, digit_two, digit_three;

  assign s_axis_tready = !full;
  assign push          = s_axis_tvalid && !full;

  sdx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .character_i (s_axis_tdata),
    .last_char_i (s_axis_tlast),
    .item_o      (item_in)
  );

  sdx_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (item_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (item_out)
  );

  sdx_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .item_i         (item_out),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .first_letter_o (first_letter),
    .digit_one_o    (digit_one),
    .digit_two_o    (digit_two),
    .digit_three_o  (digit_three)
  );

  assign m_axis_tdata = {7'd0, digit_three, digit_two, digit_one, first_letter};

endmodule

### rtl/sdx_front.sv
`timescale 1ns / 1ps
module sdx_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [7:0]        character_i,
  input  logic              last_char_i,
  output sdx_pkg::sdx_item_t item_o
);

  logic       word_started_q, word_started_d;
  logic [7:0] upper;
  logic [2:0] code;
  logic [2:0] lead_digit;

  always_comb begin
    upper = character_i;
    if (character_i >= 8'h61 && character_i <= 8'h7a) begin
      upper = character_i - 8'd32;
    end
  end

  always_comb begin
    case (upper)
      8'h42, 8'h46, 8'h50, 8'h56:                             code = 3'd1;
      8'h43, 8'h47, 8'h4a, 8'h4b, 8'h51, 8'h53, 8'h58, 8'h5a: code = 3'd2;
      8'h44, 8'h54:                                           code = 3'd3;
      8'h4c:                                                  code = 3'd4;
      8'h4d, 8'h4e:                                           code = 3'd5;
      8'h52:                                                  code = 3'd6;
      default:                                                code = 3'd0;
    endcase
  end

  // a leading '1'..'6' counts as the previous code
  always_comb begin
    lead_digit = 3'd0;
    if (character_i >= 8'h31 && character_i <= 8'h36) begin
      lead_digit = 3'(character_i - 8'h30);
    end
  end

  always_comb begin
    item_o.first = !word_started_q;
    item_o.zero  = (character_i == 8'd0);
    item_o.lead  = (character_i == 8'd0) ? 8'h30 : upper;
    item_o.code  = word_started_q ? code : lead_digit;
    item_o.last  = last_char_i;
  end

  always_comb begin
    word_started_d = word_started_q;
    if (push_i) begin
      word_started_d = !last_char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_started_q <= 1'b0;
    end else begin
      word_started_q <= word_started_d;
    end
  end

endmodule

### rtl/sdx_fifo.sv
`timescale 1ns / 1ps
module sdx_fifo #(
  parameter int unsigned Depth = sdx_pkg::SDX_FIFO_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sdx_pkg::sdx_item_t wdata_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output sdx_pkg::sdx_item_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(Depth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  sdx_pkg::sdx_item_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == DepthC);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue underflow");
`endif

endmodule

### rtl/sdx_back.sv
`timescale 1ns / 1ps
module sdx_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  sdx_pkg::sdx_item_t item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         first_letter_o,
  output logic [2:0]         digit_one_o,
  output logic [2:0]         digit_two_o,
  output logic [2:0]         digit_three_o
);

  localparam int unsigned LenW = $clog2(sdx_pkg::SDX_DIGITS + 1);
  localparam logic [LenW-1:0] MaxLen = LenW'(sdx_pkg::SDX_DIGITS);

  logic [LenW-1:0] len_q, len_d;
  logic            stopped_q, stopped_d;
  logic [7:0]      lead_q, lead_d;
  logic [2:0]      prev_q, prev_d;
  logic [2:0]      dig_q [sdx_pkg::SDX_DIGITS];
  logic [2:0]      dig_d [sdx_pkg::SDX_DIGITS];
  logic            append;

  logic            ovalid_q, ovalid_d;
  logic [7:0]      olead_q;
  logic [2:0]      odig_q [sdx_pkg::SDX_DIGITS];

  // a last byte waits until the result register frees up
  assign pop_o = !empty_i && (!item_i.last || !ovalid_q || out_ready_i);

  assign append = !item_i.first && !stopped_q && !item_i.zero && (item_i.code != 3'd0)
                  && (item_i.code != prev_q) && (len_q < MaxLen);

  always_comb begin
    len_d     = len_q;
    stopped_d = stopped_q;
    lead_d    = lead_q;
    prev_d    = prev_q;
    dig_d     = dig_q;
    if (item_i.first) begin
      len_d     = '0;
      lead_d    = item_i.lead;
      prev_d    = item_i.code;
      stopped_d = item_i.zero;
    end else if (!stopped_q) begin
      if (item_i.zero) begin
        stopped_d = 1'b1;
      end else if (append) begin
        dig_d[len_q[LenW-1:0]] = item_i.code;
        len_d  = len_q + 1'b1;
        prev_d = item_i.code;
        if (len_q + 1'b1 >= MaxLen) begin
          stopped_d = 1'b1;
        end
      end
    end
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
    if (pop_o && item_i.last) begin
      ovalid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      stopped_q <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
      if (pop_o) begin
        len_q     <= len_d;
        stopped_q <= stopped_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      lead_q <= lead_d;
      prev_q <= prev_d;
      dig_q  <= dig_d;
    end
    if (pop_o && item_i.last) begin
      olead_q <= lead_d;
      for (int i = 0; i < int'(sdx_pkg::SDX_DIGITS); i++) begin
        odig_q[i] <= (LenW'(i) < len_d) ? dig_d[i] : 3'd0;
      end
    end
  end

  assign out_valid_o    = ovalid_q;
  assign first_letter_o = olead_q;
  assign digit_one_o    = odig_q[0];
  assign digit_two_o    = odig_q[1];
  assign digit_three_o  = odig_q[2];

`ifndef SYNTHESIS
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= MaxLen) else $error("code length out of range");
  a_full_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q == MaxLen) |-> stopped_q) else $error("full code not stopped");
`endif

endmodule

### test/soundex_code_checker.sv
`timescale 1ns / 1ps
module soundex_code_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        byte_valid_i,
  input  logic        byte_ready_i,
  input  logic [7:0]  byte_data_i,   // [7:0] character
  input  logic        byte_last_i,
  input  logic        code_valid_i,
  input  logic        code_ready_i,
  input  logic [23:0] code_data_i,   // [7:0] first_letter, [10:8] digit_one,
                                     // [13:11] digit_two, [16:14] digit_three
  output int unsigned fail_count_o,
  output int unsigned codes_pending_o
);

  typedef struct {
    logic [7:0] lead;
    logic [2:0] d1;
    logic [2:0] d2;
    logic [2:0] d3;
  } sdx_code_t;

  sdx_code_t   codes_due[$];
  sdx_code_t   want;
  int unsigned fail_cnt = 0;
  int unsigned pending_cnt = 0;

  // word in progress: entry 0 holds the lead, entries 1..3 the digits as ASCII
  logic       lead_seen;
  logic [2:0] digit_cnt;
  logic       halted;
  logic [7:0] sdx_chars [4];

  assign fail_count_o    = fail_cnt;
  assign codes_pending_o = pending_cnt;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    if (c >= "a" && c <= "z") begin
      return c - 8'd32;
    end
    return c;
  endfunction

  // ASCII digit for a coded letter, zero for a skipped byte
  function automatic logic [7:0] digit_char(input logic [7:0] c);
    case (upcase(c))
      "B", "F", "P", "V": return "1";
      "C", "G", "J", "K", "Q", "S", "X", "Z": return "2";
      "D", "T": return "3";
      "L": return "4";
      "M", "N": return "5";
      "R": return "6";
      default: return 8'h00;
    endcase
  endfunction

  task automatic clear_word();
    lead_seen = 1'b0;
    digit_cnt = '0;
    halted    = 1'b0;
    for (int i = 0; i < 4; i++) begin
      sdx_chars[i] = 8'h00;
    end
  endtask

  task automatic report(input string msg);
    $display("%0t soundex mismatch: %s", $time, msg);
    fail_cnt++;
  endtask

  task automatic soundex_absorb(input logic [7:0] ch, input logic last);
    logic [7:0] dc;
    sdx_code_t  res;
    if (!lead_seen) begin
      lead_seen = 1'b1;
      digit_cnt = '0;
      if (ch == 8'h00) begin
        sdx_chars[0] = "0";
        halted = 1'b1;
      end else begin
        sdx_chars[0] = upcase(ch);
        halted = 1'b0;
      end
    end else if (!halted) begin
      if (ch == 8'h00) begin
        halted = 1'b1;
      end else begin
        dc = digit_char(ch);
        // drop a code equal to the previous character, lead included
        if (dc != 8'h00 && dc != sdx_chars[digit_cnt] && digit_cnt < 3) begin
          digit_cnt = digit_cnt + 3'd1;
          sdx_chars[digit_cnt] = dc;
        end
        if (digit_cnt >= 3) begin
          halted = 1'b1;
        end
      end
    end
    if (last) begin
      // ASCII '1'..'6' carry the digit value in their low three bits
      res.lead = sdx_chars[0];
      res.d1   = (digit_cnt >= 1) ? sdx_chars[1][2:0] : 3'd0;
      res.d2   = (digit_cnt >= 2) ? sdx_chars[2][2:0] : 3'd0;
      res.d3   = (digit_cnt >= 3) ? sdx_chars[3][2:0] : 3'd0;
      codes_due.push_back(res);
      clear_word();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_word();
      codes_due.delete();
      pending_cnt = 0;
    end else begin
      if (code_valid_i && code_ready_i) begin
        if (codes_due.size() == 0) begin
          report($sformatf("code %06h with none expected", code_data_i));
        end else begin
          want = codes_due.pop_front();
          if (code_data_i[7:0] != want.lead) begin
            report($sformatf("first_letter got %02h want %02h", code_data_i[7:0], want.lead));
          end
          if (code_data_i[10:8] != want.d1) begin
            report($sformatf("digit_one got %0d want %0d", code_data_i[10:8], want.d1));
          end
          if (code_data_i[13:11] != want.d2) begin
            report($sformatf("digit_two got %0d want %0d", code_data_i[13:11], want.d2));
          end
          if (code_data_i[16:14] != want.d3) begin
            report($sformatf("digit_three got %0d want %0d", code_data_i[16:14], want.d3));
          end
        end
      end
      if (byte_valid_i && byte_ready_i) begin
        soundex_absorb(byte_data_i, byte_last_i);
      end
      pending_cnt = codes_due.size();
    end
  end

endmodule

### test/soundex_encoder_tb.sv
`timescale 1ns / 1ps
module soundex_encoder_tb;

  localparam int unsigned BYTE_TARGET  = 1650;
  localparam int unsigned CALM_FROM    = 1350;
  localparam int unsigned HOLD_AT      = 600;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef enum int unsigned {
    WORD_EMPTY,
    WORD_NOISE,
    WORD_DIGIT_LEAD,
    WORD_LETTERS
  } word_kind_e;

  localparam string CODE_LETTERS  = "BFPVCGJKQSXZDTLMNR";
  localparam string OTHER_LETTERS = "AEIOUYHW";

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] character
  logic        s_axis_tlast;   // last_char
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [7:0] first_letter, [10:8] digit_one,
                               // [13:11] digit_two, [16:14] digit_three

  int unsigned fail_count;
  int unsigned codes_pending;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;
  logic        calm = 1'b0;
  logic        hold_req = 1'b0;
  logic [7:0]  word_buf[$];

  always #4 clk_i = ~clk_i;

  soundex_encoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  soundex_code_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_valid_i   (s_axis_tvalid),
    .byte_ready_i   (s_axis_tready),
    .byte_data_i    (s_axis_tdata),
    .byte_last_i    (s_axis_tlast),
    .code_valid_i   (m_axis_tvalid),
    .code_ready_i   (m_axis_tready),
    .code_data_i    (m_axis_tdata),
    .fail_count_o   (fail_count),
    .codes_pending_o(codes_pending)
  );

  // offer one byte from a falling edge, return at a falling edge after acceptance and any idle gap
  task automatic send_byte(input logic [7:0] ch, input logic last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
  endtask

  task automatic send_word();
    for (int i = 0; i < word_buf.size(); i++) begin
      send_byte(word_buf[i], i == word_buf.size() - 1);
    end
  endtask

  task automatic load_text(input string s);
    word_buf.delete();
    for (int i = 0; i < s.len(); i++) begin
      word_buf.push_back(s[i]);
    end
  endtask

  function automatic logic [7:0] any_case(input logic [7:0] c);
    return ($urandom_range(0, 1) != 0) ? (c | 8'h20) : c;
  endfunction

  task automatic make_random_word();
    word_kind_e  kind;
    int unsigned len;
    int unsigned pick;
    word_buf.delete();
    len = $urandom_range(1, 8);
    case ($urandom_range(0, 19))
      0: kind = WORD_EMPTY;
      1, 2: kind = WORD_NOISE;
      3, 4: kind = WORD_DIGIT_LEAD;
      default: kind = WORD_LETTERS;
    endcase
    case (kind)
      WORD_EMPTY: word_buf.push_back(8'h00);
      WORD_NOISE: word_buf.push_back(8'($urandom_range(0, 255)));
      WORD_DIGIT_LEAD: word_buf.push_back(8'h30 + 8'($urandom_range(1, 6)));
      default: word_buf.push_back(any_case(CODE_LETTERS[$urandom_range(0, 17)]));
    endcase
    while (word_buf.size() < len) begin
      pick = $urandom_range(0, 39);
      if (pick == 0) begin
        word_buf.push_back(8'h00);
      end else if (pick <= 2 || kind == WORD_NOISE) begin
        word_buf.push_back(8'($urandom_range(0, 255)));
      end else if (pick <= 10) begin
        word_buf.push_back(any_case(OTHER_LETTERS[$urandom_range(0, 7)]));
      end else begin
        word_buf.push_back(any_case(CODE_LETTERS[$urandom_range(0, 17)]));
      end
    end
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty word, then a leading zero followed by letters
    word_buf.delete();
    word_buf.push_back(8'h00);
    send_word();
    word_buf.delete();
    word_buf.push_back(8'h00);
    word_buf.push_back("B");
    word_buf.push_back("d");
    send_word();
    load_text("robert");
    send_word();
    // leading digit suppresses the matching code
    load_text("3dt");
    send_word();
    // zero inside a word cuts it off
    word_buf.delete();
    word_buf.push_back("T");
    word_buf.push_back("a");
    word_buf.push_back(8'h00);
    word_buf.push_back("m");
    send_word();
    word_buf.delete();
    word_buf.push_back(8'hFF);
    word_buf.push_back(8'h80);
    send_word();
    // code full, trailing letter ignored
    load_text("bcdlm");
    send_word();
    load_text("q");
    send_word();

    while (bytes_sent < BYTE_TARGET) begin
      if (bytes_sent >= HOLD_AT) hold_req <= 1'b1;
      if (bytes_sent >= CALM_FROM) calm <= 1'b1;
      make_random_word();
      send_word();
    end
    s_axis_tvalid <= 1'b0;

    while (codes_pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[soundex_encoder] OK");
    end else begin
      $display("[soundex_encoder] ERROR");
    end
    $finish;
  end

  // result side: random stall bursts, one long hold-off to back up the block
  initial begin
    int unsigned stall;
    logic        hold_done;
    m_axis_tready = 1'b0;
    stall = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      if (stall == 0 && !calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 14);
      end
      if (stall != 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("[soundex_encoder] ERROR");
        $finish;
      end
    end
  end

endmodule
